### design/shell_variable_reference_tokenizer_unit_macros.svh
// Assertion macros used by the tokenizer top-level design file.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SHELL_VARIABLE_REFERENCE_TOKENIZER_UNIT_MACROS_SVH
`define SHELL_VARIABLE_REFERENCE_TOKENIZER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVRT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVRT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/svrt_pkg.sv
package svrt_pkg;

	localparam int MAX_DEPTH   = 255;
	localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
	localparam int MAX_RESULTS = 3;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int SLOT_W      = $clog2(MAX_RESULTS);

	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_LBRACKET  = 8'h5b;
	localparam logic [7:0] CH_RBRACKET  = 8'h5d;
	localparam logic [7:0] CH_LBRACE    = 8'h7b;
	localparam logic [7:0] CH_RBRACE    = 8'h7d;
	localparam logic [7:0] CH_UNDERLINE = 8'h5f;

	typedef enum logic [5:0] {
		PH_TEXT    = 6'b000001,
		PH_DOLLAR  = 6'b000010,
		PH_NAME    = 6'b000100,
		PH_BRACKET = 6'b001000,
		PH_BRACE   = 6'b010000,
		PH_ERROR   = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		K_LIT  = 3'd0,
		K_NAME = 3'd1,
		K_END  = 3'd2,
		K_STR  = 3'd3,
		K_ERR  = 3'd4
	} tok_kind_t;

	typedef enum logic [1:0] {
		E_BAD_CHAR = 2'd0,
		E_BRACKET  = 2'd1,
		E_BRACE    = 2'd2,
		E_DEPTH    = 2'd3
	} err_kind_t;

	typedef struct packed {
		phase_t               phase;
		logic                 held;
		logic [DEPTH_W-1:0]   depth;
	} state_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] data;
		err_kind_t  err;
		logic       last;
	} tok_t;

	typedef struct packed {
		tok_t [MAX_RESULTS-1:0] slot;
		logic [CNT_W-1:0]       count;
	} res_t;

	localparam state_t STATE_RESET = '{phase: PH_TEXT, held: 1'b0, depth: '0};

	function automatic logic is_alpha(logic [7:0] c);
		return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
	endfunction

	function automatic logic is_name_char(logic [7:0] c);
		return is_alpha(c) || (c inside {[8'h30:8'h39]}) || (c == CH_UNDERLINE);
	endfunction

	function automatic tok_t mk_tok(tok_kind_t k, logic [7:0] b, err_kind_t e);
		tok_t t;
		t.kind = k;
		t.data = b;
		t.err  = e;
		t.last = 1'b0;
		return t;
	endfunction

	// Appends a token; anything past the last slot is dropped.
	function automatic res_t push(res_t r, tok_t t);
		res_t o;
		o = r;
		if (r.count < CNT_W'(MAX_RESULTS)) begin
			o.slot[r.count[SLOT_W-1:0]] = t;
			o.count = CNT_W'(r.count + CNT_W'(1));
		end
		return o;
	endfunction

endpackage

### design/svrt_step.sv
module svrt_step (
	input  svrt_pkg::state_t cur,
	input  logic [7:0]       c,
	input  logic             eos,
	output svrt_pkg::state_t nxt,
	output svrt_pkg::res_t   res
);
	import svrt_pkg::*;

	res_t       r;
	state_t     n;
	logic       do_top;
	logic       skip;
	logic       in_bracket;
	logic [7:0] opener;
	logic [7:0] closer;

	always_comb begin
		r          = '0;
		n          = cur;
		do_top     = 1'b0;
		skip       = 1'b0;
		in_bracket = (cur.phase == PH_BRACKET);
		opener     = in_bracket ? CH_LBRACKET : CH_LBRACE;
		closer     = in_bracket ? CH_RBRACKET : CH_RBRACE;

		case (cur.phase)
			PH_DOLLAR: begin
				if (is_alpha(c) || c == CH_UNDERLINE) begin
					r       = push(r, mk_tok(K_NAME, c, E_BAD_CHAR));
					n.phase = PH_NAME;
				end else if (c == CH_LBRACE) begin
					n.depth = DEPTH_W'(1);
					n.phase = PH_BRACE;
				end else begin
					r       = push(r, mk_tok(K_ERR, 8'h00, E_BAD_CHAR));
					n.phase = PH_ERROR;
					n.depth = '0;
				end
			end
			PH_NAME: begin
				if (is_name_char(c)) begin
					r = push(r, mk_tok(K_NAME, c, E_BAD_CHAR));
				end else if (c == CH_LBRACKET) begin
					r       = push(r, mk_tok(K_NAME, c, E_BAD_CHAR));
					n.depth = DEPTH_W'(1);
					n.phase = PH_BRACKET;
				end else begin
					r       = push(r, mk_tok(K_END, 8'h00, E_BAD_CHAR));
					n.phase = PH_TEXT;
					do_top  = 1'b1;
				end
			end
			PH_BRACKET, PH_BRACE: begin
				if (c == opener) begin
					if (cur.depth >= DEPTH_W'(MAX_DEPTH)) begin
						r       = push(r, mk_tok(K_ERR, 8'h00, E_DEPTH));
						n.phase = PH_ERROR;
						n.depth = '0;
					end else begin
						n.depth = DEPTH_W'(cur.depth + DEPTH_W'(1));
						r       = push(r, mk_tok(K_NAME, c, E_BAD_CHAR));
					end
				end else if (c == closer) begin
					n.depth = (cur.depth != '0) ? DEPTH_W'(cur.depth - DEPTH_W'(1)) : '0;
					if (n.depth == '0) begin
						// The closing bracket belongs to the name; the outer brace does not.
						if (in_bracket) begin
							r = push(r, mk_tok(K_NAME, c, E_BAD_CHAR));
						end
						r       = push(r, mk_tok(K_END, 8'h00, E_BAD_CHAR));
						n.phase = PH_TEXT;
					end else begin
						r = push(r, mk_tok(K_NAME, c, E_BAD_CHAR));
					end
				end else begin
					r = push(r, mk_tok(K_NAME, c, E_BAD_CHAR));
				end
			end
			PH_ERROR: begin
			end
			default: begin
				n.phase = PH_TEXT;
				do_top  = 1'b1;
			end
		endcase

		// Plain text: a backslash is held back in case a dollar follows it.
		if (do_top) begin
			if (n.held) begin
				n.held = 1'b0;
				if (c == CH_DOLLAR) begin
					r    = push(r, mk_tok(K_LIT, CH_DOLLAR, E_BAD_CHAR));
					skip = 1'b1;
				end else begin
					r = push(r, mk_tok(K_LIT, CH_BACKSLASH, E_BAD_CHAR));
				end
			end
			if (!skip) begin
				if (c == CH_BACKSLASH) begin
					n.held = 1'b1;
				end else if (c == CH_DOLLAR) begin
					n.phase = PH_DOLLAR;
				end else begin
					r = push(r, mk_tok(K_LIT, c, E_BAD_CHAR));
				end
			end
		end

		if (eos) begin
			case (n.phase)
				PH_TEXT: begin
					if (n.held) begin
						r = push(r, mk_tok(K_LIT, CH_BACKSLASH, E_BAD_CHAR));
					end
				end
				PH_DOLLAR:  r = push(r, mk_tok(K_LIT, CH_DOLLAR, E_BAD_CHAR));
				PH_NAME:    r = push(r, mk_tok(K_END, 8'h00, E_BAD_CHAR));
				PH_BRACKET: r = push(r, mk_tok(K_ERR, 8'h00, E_BRACKET));
				PH_BRACE:   r = push(r, mk_tok(K_ERR, 8'h00, E_BRACE));
				default: begin
				end
			endcase
			r = push(r, mk_tok(K_STR, 8'h00, E_BAD_CHAR));
			n = STATE_RESET;
		end

		if (r.count != '0) begin
			r.slot[SLOT_W'(r.count - CNT_W'(1))].last = 1'b1;
		end
	end

	assign nxt = n;
	assign res = r;

endmodule

### design/shell_variable_reference_tokenizer_unit.sv
// Shell variable reference tokenizer. Bytes of a string arrive on the s_ stream, one per
// transaction, with s_tlast marking the final byte; tokens leave on the m_ stream: literal
// bytes, variable-name bytes, a name-end mark after each $name, $name[...] or ${...}, a
// string-end mark after every string, and errors (bad character after a dollar, an unclosed
// bracket or brace, or nesting beyond 255 levels), after which the rest of that string only
// yields its string-end mark. Each byte gives zero to three tokens; m_tlast flags the final
// token of each byte. A byte is captured in an input register, decoded combinationally and
// written into a three-entry result buffer, which drains at one token per cycle while
// m_tready is high. Throughput is one byte per cycle while each byte yields at most one
// token and the output does not stall; a byte that yields more holds the buffer until its
// last token leaves. A byte reaches the output through the input register, then the buffer.
`include "shell_variable_reference_tokenizer_unit_macros.svh"

module shell_variable_reference_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_byte
	output logic [4:0] m_tuser,   // [2:0] token_kind, [4:3] error_kind
	output logic       m_tlast    // run_last
);
	import svrt_pkg::*;

	// Input register: one byte waiting to be decoded.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;

	// Scanner state: phase, held backslash and nesting depth.
	state_t st_q;
	state_t st_next;
	res_t   step_res;

	// Result buffer: slot 0 is always the token on offer.
	tok_t [MAX_RESULTS-1:0] slot_q;
	logic [CNT_W-1:0]       cnt_q;

	logic pop;
	logic advance;

	assign pop = m_tvalid && m_tready;

	// The decoded byte may enter the buffer once it is empty or its last token is leaving.
	assign advance  = valid_s1 && ((cnt_q == '0) || (cnt_q == CNT_W'(1) && pop));
	assign s_tready = !valid_s1 || advance;

	svrt_step u_step (
		.cur (st_q),
		.c   (char_s1),
		.eos (eos_s1),
		.nxt (st_next),
		.res (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= STATE_RESET;
			cnt_q    <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				st_q  <= st_next;
				cnt_q <= step_res.count;
			end else if (pop) begin
				cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
		if (advance) begin
			slot_q <= step_res.slot;
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = slot_q[0].data;
	assign m_tuser  = {slot_q[0].err, slot_q[0].kind};
	assign m_tlast  = slot_q[0].last;

	// A byte's final token leaving empties the buffer unless the next byte was loaded.
	`SVRT_ASSERT_NEXT(a_last_drains, pop && m_tlast, cnt_q == '0 || $past(advance), "tokens left after last")
	// More tokens of the same byte are still on offer after a non-final token.
	`SVRT_ASSERT_NEXT(a_run_continues, pop && !m_tlast, m_tvalid, "token run broken")
	// Bytes after an error produce nothing until the string ends.
	`SVRT_ASSERT_NEXT(a_error_silent, advance && st_q.phase == PH_ERROR && !eos_s1, cnt_q == '0, "token after error")
	// Nesting depth is only held inside a bracket or brace.
	`SVRT_ASSERT_NOW(a_depth_phase, st_q.depth != '0, st_q.phase == PH_BRACKET || st_q.phase == PH_BRACE, "stray depth")

endmodule
